// ===== hw/rtl/lrdd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lrdd_pkg;

  localparam int NUM_SENSORS  = 18;
  localparam int SAMPLE_BITS  = 10;
  localparam int MARGIN_BITS  = 10;
  localparam int IDX_BITS     = 5;
  localparam int SUM_BITS     = 20;
  localparam int ROM_BITS     = 16;
  localparam int CW           = 23;
  localparam int ZW           = 27;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int K_BITS       = 4;
  localparam int PAIRS        = 9;
  localparam int CORNER_FIRST = 4;
  localparam int SW = ((SAMPLE_BITS > MARGIN_BITS) ? SAMPLE_BITS : MARGIN_BITS) + 1;

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(35);
  localparam logic [7:0]             ANGLE_NONE   = 8'd250;
  localparam logic [3:0]             DEPTH_NONE   = 4'd15;
  localparam logic [1:0]             CORNER_NONE  = 2'd0;
  localparam logic [1:0]             CORNER_RIGHT = 2'd1;
  localparam logic [1:0]             CORNER_LEFT  = 2'd2;

  localparam logic signed [ZW-1:0] Z_DEG90  = 27'sd5898240;
  localparam logic signed [ZW-1:0] Z_DEG180 = 27'sd11796480;
  localparam logic signed [ZW-1:0] Z_DEG360 = 27'sd23592960;

  // Q14 unit vectors, sensor i at i*20 degrees
  localparam logic signed [ROM_BITS-1:0] RING_COS [NUM_SENSORS] = '{
    16'sd16384, 16'sd15396, 16'sd12551, 16'sd8192, 16'sd2845, -16'sd2845,
    -16'sd8192, -16'sd12551, -16'sd15396, -16'sd16384, -16'sd15396, -16'sd12551,
    -16'sd8192, -16'sd2845, 16'sd2845, 16'sd8192, 16'sd12551, 16'sd15396};
  localparam logic signed [ROM_BITS-1:0] RING_SIN [NUM_SENSORS] = '{
    16'sd0, 16'sd5604, 16'sd10531, 16'sd14189, 16'sd16135, 16'sd16135,
    16'sd14189, 16'sd10531, 16'sd5604, 16'sd0, -16'sd5604, -16'sd10531,
    -16'sd14189, -16'sd16135, -16'sd16135, -16'sd14189, -16'sd10531, -16'sd5604};

  // atan(2^-k) in degrees * 65536
  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379,
    27'sd117304, 27'sd58666, 27'sd29335, 27'sd14668, 27'sd7334, 27'sd3667,
    27'sd1833, 27'sd917, 27'sd458, 27'sd229, 27'sd115};

  typedef struct packed {
    logic              take;
    logic              prep;
    logic              step;
    logic              load;
    logic [K_BITS-1:0] k;
  } lrdd_cmd_t;

  typedef struct packed {
    logic close;
    logic prep_done;
    logic y_zero_next;
    logic out_free;
  } lrdd_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrdd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lrdd_in_if import lrdd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [IDX_BITS-1:0]    sensor_index;
  logic [SAMPLE_BITS-1:0] reading;
  logic                   frame_end;

  modport source (output valid, kind, sensor_index, reading, frame_end, input ready);
  modport sink (input valid, kind, sensor_index, reading, frame_end, output ready);
endinterface

interface lrdd_out_if import lrdd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   line_found;
  logic [7:0]             angle_half;
  logic [3:0]             line_depth;
  logic [1:0]             corner_side;
  logic [NUM_SENSORS-1:0] detected_mask;

  modport source (output valid, line_found, angle_half, line_depth, corner_side,
                  detected_mask, input ready);
  modport sink (input valid, line_found, angle_half, line_depth, corner_side,
                detected_mask, output ready);
endinterface

interface lrdd_cfg_if import lrdd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MARGIN_BITS-1:0] detect_margin;

  modport source (output valid, detect_margin, input ready);
  modport sink (input valid, detect_margin, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lrdd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrdd_ctrl import lrdd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  lrdd_status_t status_i,
  output lrdd_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_ITER = 4'b0100,
    ST_FIN  = 4'b1000
  } lrdd_state_e;

  lrdd_state_e       state_q, state_d;
  logic [K_BITS-1:0] k_q, k_d;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.k    = k_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        k_d        = '0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.close) begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.prep_done ? ST_FIN : ST_ITER;
      end
      ST_ITER: begin
        cmd_o.step = 1'b1;
        k_d        = k_q + 1'b1;
        if (k_q == K_BITS'(CORDIC_STEPS - 1) || status_i.y_zero_next) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lrdd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrdd_dp import lrdd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lrdd_cmd_t              cmd_i,
  output lrdd_status_t           status_o,
  input  logic                   kind_i,
  input  logic [IDX_BITS-1:0]    sensor_index_i,
  input  logic [SAMPLE_BITS-1:0] reading_i,
  input  logic                   frame_end_i,
  input  logic                   cfg_valid_i,
  input  logic [MARGIN_BITS-1:0] cfg_margin_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   line_found_o,
  output logic [7:0]             angle_half_o,
  output logic [3:0]             line_depth_o,
  output logic [1:0]             corner_side_o,
  output logic [NUM_SENSORS-1:0] detected_mask_o
);

  logic [MARGIN_BITS-1:0] margin_q;
  logic [SAMPLE_BITS-1:0] cal_q [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] fmask_q, wmask_q;
  logic [SUM_BITS-1:0]    sum_x_q, sum_y_q;
  logic signed [CW-1:0]   x_q, y_q;
  logic signed [ZW-1:0]   z_q;
  logic [3:0]             held_q;
  logic [1:0]             corner_q;

  logic                   out_valid_q;
  logic                   out_found_q;
  logic [7:0]             out_angle_q;
  logic [3:0]             out_depth_q;
  logic [1:0]             out_corner_q;
  logic [NUM_SENSORS-1:0] out_mask_q;

  // reading intake
  logic [SAMPLE_BITS-1:0]     cal_sel;
  logic signed [ROM_BITS-1:0] cos_sel, sin_sel;
  logic [NUM_SENSORS-1:0]     idx_hot, mask_n;
  logic                       idx_ok, hit;
  logic [SW-1:0]              thr;
  logic [SUM_BITS-1:0]        sum_x_n, sum_y_n;

  always_comb begin
    cal_sel = '1;
    cos_sel = '0;
    sin_sel = '0;
    idx_hot = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (sensor_index_i == IDX_BITS'(i)) begin
        cal_sel    = cal_q[i];
        cos_sel    = RING_COS[i];
        sin_sel    = RING_SIN[i];
        idx_hot[i] = 1'b1;
      end
    end
    idx_ok  = sensor_index_i < IDX_BITS'(NUM_SENSORS);
    thr     = SW'(reading_i) + SW'(margin_q);
    hit     = !kind_i && idx_ok && (thr < SW'(cal_sel));
    mask_n  = fmask_q | (hit ? idx_hot : '0);
    sum_x_n = sum_x_q + (hit ? {{(SUM_BITS-ROM_BITS){cos_sel[ROM_BITS-1]}}, cos_sel} : '0);
    sum_y_n = sum_y_q + (hit ? {{(SUM_BITS-ROM_BITS){sin_sel[ROM_BITS-1]}}, sin_sel} : '0);
  end

  // depth and corner from the closed frame mask
  logic [NUM_SENSORS+1:0] pm;
  logic                   dep_hit;
  logic [3:0]             dep_sel;
  logic [1:0]             corner_d;

  always_comb begin
    int mi;
    logic l, r;
    pm       = {1'b0, wmask_q, 1'b0};
    dep_hit  = 1'b0;
    dep_sel  = DEPTH_NONE;
    corner_d = CORNER_NONE;
    for (int i = PAIRS - 1; i >= 0; i--) begin
      mi = NUM_SENSORS - 1 - i;
      l  = pm[i+1];
      r  = pm[mi+1];
      if ((l && r) || (l && (pm[mi] || pm[mi+2])) || (r && (pm[i] || pm[i+2]))) begin
        dep_hit = 1'b1;
        dep_sel = 4'(i + 1);
      end
    end
    for (int i = PAIRS - 1; i >= CORNER_FIRST; i--) begin
      mi = NUM_SENSORS - 1 - i;
      if (pm[i+1]) begin
        if (!pm[mi] && !pm[mi+1] && !pm[mi+2]) begin
          corner_d = CORNER_LEFT;
        end
      end else if (pm[mi+1]) begin
        if (!pm[i] && !pm[i+1] && !pm[i+2]) begin
          corner_d = CORNER_RIGHT;
        end
      end
    end
  end

  // quadrant fold and special angles
  logic signed [CW-1:0] px, py;
  logic signed [ZW-1:0] pz;
  logic                 y_pos;

  always_comb begin
    y_pos = !y_q[CW-1] && (y_q != '0);
    px    = x_q;
    py    = y_q;
    pz    = '0;
    if (y_q == '0) begin
      pz = x_q[CW-1] ? Z_DEG180 : '0;
    end else if (x_q == '0) begin
      pz = y_pos ? Z_DEG90 : -Z_DEG90;
    end else if (x_q[CW-1]) begin
      if (y_pos) begin
        px = y_q;
        py = -x_q;
        pz = Z_DEG90;
      end else begin
        px = -y_q;
        py = x_q;
        pz = -Z_DEG90;
      end
    end
  end

  // one CORDIC vectoring step
  logic signed [CW-1:0] xs, ys, nx, ny;
  logic signed [ZW-1:0] nz;

  always_comb begin
    xs = x_q >>> cmd_i.k;
    ys = y_q >>> cmd_i.k;
    if (y_pos) begin
      nx = x_q + ys;
      ny = y_q - xs;
      nz = z_q + ATAN_TAB[cmd_i.k];
    end else begin
      nx = x_q - ys;
      ny = y_q + xs;
      nz = z_q - ATAN_TAB[cmd_i.k];
    end
  end

  // final angle
  logic signed [ZW-1:0] tot, tot_c;
  logic [7:0]           half_d;

  always_comb begin
    tot = z_q + Z_DEG180;
    if (tot < 0) begin
      tot_c = '0;
    end else if (tot > Z_DEG360) begin
      tot_c = Z_DEG360;
    end else begin
      tot_c = tot;
    end
    half_d = tot_c[FRAC_BITS+8:FRAC_BITS+1];
  end

  assign status_o.close       = !kind_i && frame_end_i;
  assign status_o.prep_done   = (wmask_q == '0) || (y_q == '0) || (x_q == '0);
  assign status_o.y_zero_next = (ny == '0);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RESET;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        cal_q[i] <= '1;
      end
      fmask_q     <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      held_q      <= DEPTH_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        margin_q <= cfg_margin_i;
      end
      if (cmd_i.take) begin
        if (kind_i) begin
          for (int i = 0; i < NUM_SENSORS; i++) begin
            if (idx_hot[i] && reading_i < cal_q[i]) begin
              cal_q[i] <= reading_i;
            end
          end
        end else if (frame_end_i) begin
          fmask_q <= '0;
          sum_x_q <= '0;
          sum_y_q <= '0;
        end else begin
          fmask_q <= mask_n;
          sum_x_q <= sum_x_n;
          sum_y_q <= sum_y_n;
        end
      end
      if (cmd_i.prep) begin
        if (wmask_q == '0) begin
          held_q <= DEPTH_NONE;
        end else if (dep_hit) begin
          held_q <= dep_sel;
        end
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && status_o.close) begin
      wmask_q <= mask_n;
      x_q     <= CW'($signed(sum_x_n));
      y_q     <= CW'($signed(sum_y_n));
    end else if (cmd_i.prep) begin
      x_q      <= px;
      y_q      <= py;
      z_q      <= pz;
      corner_q <= corner_d;
    end else if (cmd_i.step) begin
      x_q <= nx;
      y_q <= ny;
      z_q <= nz;
    end
    if (cmd_i.load) begin
      out_found_q  <= (wmask_q != '0);
      out_angle_q  <= (wmask_q != '0) ? half_d : ANGLE_NONE;
      out_depth_q  <= held_q;
      out_corner_q <= corner_q;
      out_mask_q   <= wmask_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_found_o    = out_found_q;
  assign angle_half_o    = out_angle_q;
  assign line_depth_o    = out_depth_q;
  assign corner_side_o   = out_corner_q;
  assign detected_mask_o = out_mask_q;

`ifndef ASSERT_OFF
  a_x_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (!x_q[CW-1] && x_q != '0))
    else $error("cordic x not positive during step");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |->
      (out_angle_q == ANGLE_NONE && out_depth_q == DEPTH_NONE &&
       out_corner_q == CORNER_NONE && out_mask_q == '0))
    else $error("empty frame result inconsistent");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_found_q) |-> (out_angle_q <= 8'd180 && out_mask_q != '0))
    else $error("found frame angle out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/line_ring_direction_depth_unit.sv =====
// Measurement and calibration transactions are taken in one cycle each.
// A frame-closing transaction yields its result after a fold state, up to 16
// CORDIC steps (stopping when y reaches zero) and a load once output is free.
// Input is held off from acceptance of a frame-closing transaction until the
// result is in the output register; that register lets the next frame start.
// Async active-low reset: minima to full scale, margin 35, depth 15, sums clear.
`timescale 1ns / 1ps
`default_nettype none

module line_ring_direction_depth_unit import lrdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrdd_cfg_if.sink    cfg_i,
  lrdd_in_if.sink     sample_i,
  lrdd_out_if.source  result_o
);

  lrdd_cmd_t    cmd;
  lrdd_status_t status;
  logic         in_ready;

  assign sample_i.ready = in_ready;
  assign cfg_i.ready    = 1'b1;

  lrdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lrdd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_i          (sample_i.kind),
    .sensor_index_i  (sample_i.sensor_index),
    .reading_i       (sample_i.reading),
    .frame_end_i     (sample_i.frame_end),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_margin_i    (cfg_i.detect_margin),
    .out_valid_o     (result_o.valid),
    .out_ready_i     (result_o.ready),
    .line_found_o    (result_o.line_found),
    .angle_half_o    (result_o.angle_half),
    .line_depth_o    (result_o.line_depth),
    .corner_side_o   (result_o.corner_side),
    .detected_mask_o (result_o.detected_mask)
  );

endmodule

`default_nettype wire

// ===== bench/line_ring_direction_depth_unit_test.sv =====
`timescale 1ns / 1ps

module line_ring_direction_depth_unit_test import lrdd_pkg::*; ();

  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 24;
  localparam int Q16_DEG180    = 180 * 65536;
  localparam int Q16_DEG90     = 90 * 65536;

  localparam logic KIND_MEASURE   = 1'b0;
  localparam logic KIND_CALIBRATE = 1'b1;

  // Q14 ring vectors and atan(2^-k) in degrees * 65536
  localparam int UNIT_X [NUM_SENSORS] = '{
    16384, 15396, 12551, 8192, 2845, -2845, -8192, -12551, -15396,
    -16384, -15396, -12551, -8192, -2845, 2845, 8192, 12551, 15396};
  localparam int UNIT_Y [NUM_SENSORS] = '{
    0, 5604, 10531, 14189, 16135, 16135, 14189, 10531, 5604,
    0, -5604, -10531, -14189, -16135, -16135, -14189, -10531, -5604};
  localparam int ARCTAN_Q16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115};

  typedef struct packed {
    logic                   kind;
    logic [IDX_BITS-1:0]    sensor_index;
    logic [SAMPLE_BITS-1:0] reading;
    logic                   frame_end;
  } sample_t;

  typedef struct packed {
    logic                   line_found;
    logic [7:0]             angle_half;
    logic [3:0]             line_depth;
    logic [1:0]             corner_side;
    logic [NUM_SENSORS-1:0] detected_mask;
  } frame_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lrdd_in_if  sample_if ();
  lrdd_out_if result_if ();
  lrdd_cfg_if cfg_if ();

  logic                   in_valid  = 1'b0;
  sample_t                in_item   = '0;
  logic                   out_ready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [MARGIN_BITS-1:0] cfg_data  = '0;

  assign sample_if.valid        = in_valid;
  assign sample_if.kind         = in_item.kind;
  assign sample_if.sensor_index = in_item.sensor_index;
  assign sample_if.reading      = in_item.reading;
  assign sample_if.frame_end    = in_item.frame_end;
  assign result_if.ready        = out_ready;
  assign cfg_if.valid           = cfg_valid;
  assign cfg_if.detect_margin   = cfg_data;

  line_ring_direction_depth_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  always begin
    #1;
    clk_i = ~clk_i;
  end

  sample_t       pending_samples [$];
  frame_result_t expected_frames [$];

  // predictor state
  logic [MARGIN_BITS-1:0]     margin_q = MARGIN_RESET;
  logic [SAMPLE_BITS-1:0]     floor_q [NUM_SENSORS] = '{default: '1};
  logic [NUM_SENSORS-1:0]     seen_q = '0;
  logic signed [SUM_BITS-1:0] acc_x = '0;
  logic signed [SUM_BITS-1:0] acc_y = '0;
  logic [3:0]                 depth_q = DEPTH_NONE;

  int mismatches     = 0;
  int frames_checked = 0;
  int samples_taken  = 0;
  int stim_count     = 0;
  int margins_used   = 0;
  int idle_cycles    = 0;
  int in_gap         = 0;
  int out_hold       = 0;
  bit in_quiet       = 1'b0;
  bit out_quiet      = 1'b0;

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [7:0] half_heading(logic signed [SUM_BITS-1:0] sx,
                                              logic signed [SUM_BITS-1:0] sy);
    longint x, y, z, t, nx, ny, total;
    x = sx;
    y = sy;
    z = 0;
    if (y == 0) begin
      z = (x < 0) ? Q16_DEG180 : 0;
    end else if (x == 0) begin
      z = (y > 0) ? Q16_DEG90 : -Q16_DEG90;
    end else begin
      if (x < 0) begin
        t = x;
        if (y > 0) begin
          x = y;
          y = -t;
          z = Q16_DEG90;
        end else begin
          x = -y;
          y = t;
          z = -Q16_DEG90;
        end
      end
      for (int k = 0; k < 16 && y != 0; k++) begin
        if (y > 0) begin
          nx = x + (y >>> k);
          ny = y - (x >>> k);
          z += ARCTAN_Q16[k];
        end else begin
          nx = x - (y >>> k);
          ny = y + (x >>> k);
          z -= ARCTAN_Q16[k];
        end
        x = nx;
        y = ny;
      end
    end
    total = z + Q16_DEG180;
    if (total < 0) total = 0;
    if (total > 2 * longint'(Q16_DEG180)) total = 2 * longint'(Q16_DEG180);
    return 8'((total >>> 16) / 2);
  endfunction

  function automatic bit sensor_on(logic [NUM_SENSORS-1:0] m, int k);
    if (k < 0 || k >= NUM_SENSORS) return 1'b0;
    return m[k];
  endfunction

  function automatic logic [3:0] pair_depth(logic [NUM_SENSORS-1:0] m, logic [3:0] prev);
    int r;
    if (m == '0) return DEPTH_NONE;
    for (int i = 0; i < NUM_SENSORS / 2; i++) begin
      r = NUM_SENSORS - 1 - i;
      if ((sensor_on(m, i) && sensor_on(m, r)) ||
          (sensor_on(m, i) && (sensor_on(m, r - 1) || sensor_on(m, r + 1))) ||
          (sensor_on(m, r) && (sensor_on(m, i - 1) || sensor_on(m, i + 1))))
        return 4'(i + 1);
    end
    return prev;
  endfunction

  function automatic logic [1:0] corner_of(logic [NUM_SENSORS-1:0] m);
    int r;
    for (int i = 4; i < NUM_SENSORS / 2; i++) begin
      r = NUM_SENSORS - 1 - i;
      if (sensor_on(m, i)) begin
        if (!sensor_on(m, r - 1) && !sensor_on(m, r) && !sensor_on(m, r + 1))
          return CORNER_LEFT;
      end else if (sensor_on(m, r)) begin
        if (!sensor_on(m, i - 1) && !sensor_on(m, i) && !sensor_on(m, i + 1))
          return CORNER_RIGHT;
      end
    end
    return CORNER_NONE;
  endfunction

  task automatic take_sample(sample_t s);
    frame_result_t want;
    if (s.kind == KIND_CALIBRATE) begin
      if (s.sensor_index < NUM_SENSORS && s.reading < floor_q[s.sensor_index])
        floor_q[s.sensor_index] = s.reading;
      return;
    end
    if (s.sensor_index < NUM_SENSORS &&
        int'(s.reading) + int'(margin_q) < int'(floor_q[s.sensor_index])) begin
      seen_q[s.sensor_index] = 1'b1;
      acc_x = acc_x + SUM_BITS'(UNIT_X[s.sensor_index]);
      acc_y = acc_y + SUM_BITS'(UNIT_Y[s.sensor_index]);
    end
    if (!s.frame_end) return;
    depth_q = pair_depth(seen_q, depth_q);
    want.line_found    = (seen_q != '0);
    want.angle_half    = (seen_q != '0) ? half_heading(acc_x, acc_y) : ANGLE_NONE;
    want.line_depth    = depth_q;
    want.corner_side   = corner_of(seen_q);
    want.detected_mask = seen_q;
    expected_frames.push_back(want);
    seen_q = '0;
    acc_x  = '0;
    acc_y  = '0;
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_frame(frame_result_t got);
    frame_result_t want;
    if (expected_frames.size() == 0) begin
      report_mismatch($sformatf("result with none expected, mask %05h", got.detected_mask));
      return;
    end
    want = expected_frames.pop_front();
    if (got.line_found !== want.line_found)
      report_mismatch($sformatf("frame %0d line_found %0b, want %0b",
                                frames_checked, got.line_found, want.line_found));
    if (got.angle_half !== want.angle_half)
      report_mismatch($sformatf("frame %0d angle_half %0d, want %0d",
                                frames_checked, got.angle_half, want.angle_half));
    if (got.line_depth !== want.line_depth)
      report_mismatch($sformatf("frame %0d line_depth %0d, want %0d",
                                frames_checked, got.line_depth, want.line_depth));
    if (got.corner_side !== want.corner_side)
      report_mismatch($sformatf("frame %0d corner_side %0d, want %0d",
                                frames_checked, got.corner_side, want.corner_side));
    if (got.detected_mask !== want.detected_mask)
      report_mismatch($sformatf("frame %0d detected_mask %05h, want %05h",
                                frames_checked, got.detected_mask, want.detected_mask));
    frames_checked++;
  endtask

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready)
        check_frame({result_if.line_found, result_if.angle_half, result_if.line_depth,
                     result_if.corner_side, result_if.detected_mask});
      if (cfg_if.valid && cfg_if.ready) margin_q = cfg_if.detect_margin;
      if (sample_if.valid && sample_if.ready) begin
        take_sample({sample_if.kind, sample_if.sensor_index, sample_if.reading,
                     sample_if.frame_end});
        samples_taken++;
      end
    end
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("** line_ring_direction_depth_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sample_if.ready) begin
      if (in_valid && $urandom_range(0, 59) == 0) in_quiet <= !in_quiet;
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_item  <= pending_samples.pop_front();
        in_valid <= 1'b1;
        in_gap   <= pick_gap(in_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) out_quiet <= !out_quiet;
      if (out_hold != 0) begin
        out_hold  <= out_hold - 1;
        out_ready <= (out_hold == 1);
      end else if (!out_quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        out_hold  <= pick_gap(1'b0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_sample(logic kind, int idx, int value, logic fend);
    pending_samples.push_back({kind, IDX_BITS'(idx), SAMPLE_BITS'(value), fend});
    stim_count++;
  endtask

  task automatic queue_directed();
    push_sample(KIND_MEASURE, 0, 1023, 1'b1);
    push_sample(KIND_MEASURE, 3, 988, 1'b0);
    push_sample(KIND_MEASURE, 3, 987, 1'b1);
    push_sample(KIND_MEASURE, 18, 0, 1'b0);
    push_sample(KIND_MEASURE, 31, 0, 1'b1);
    push_sample(KIND_CALIBRATE, 5, 1023, 1'b1);
    push_sample(KIND_CALIBRATE, 31, 0, 1'b0);
    // same sensor three times: angle lands exactly on 180
    push_sample(KIND_MEASURE, 9, 0, 1'b0);
    push_sample(KIND_MEASURE, 9, 0, 1'b0);
    push_sample(KIND_MEASURE, 9, 0, 1'b1);
    push_sample(KIND_MEASURE, 4, 0, 1'b1);
    push_sample(KIND_MEASURE, 13, 0, 1'b1);
    push_sample(KIND_MEASURE, 0, 0, 1'b0);
    push_sample(KIND_MEASURE, 17, 0, 1'b1);
    push_sample(KIND_MEASURE, 4, 0, 1'b0);
    push_sample(KIND_MEASURE, 5, 0, 1'b1);
    push_sample(KIND_MEASURE, 0, 0, 1'b1);
  endtask

  task automatic queue_scan();
    logic [NUM_SENSORS-1:0] hits;
    int start, span;
    hits = '0;
    case ($urandom_range(0, 5))
      0: begin
        start = $urandom_range(0, NUM_SENSORS - 1);
        span  = $urandom_range(1, 6);
        for (int j = 0; j < span; j++) hits[(start + j) % NUM_SENSORS] = 1'b1;
      end
      1: begin
        repeat (2) begin
          start = $urandom_range(0, NUM_SENSORS - 1);
          span  = $urandom_range(1, 3);
          for (int j = 0; j < span; j++) hits[(start + j) % NUM_SENSORS] = 1'b1;
        end
      end
      2: begin
        start = $urandom_range(0, NUM_SENSORS / 2 - 1);
        hits[start] = 1'b1;
        if ($urandom_range(0, 1) == 0) hits[NUM_SENSORS - 1 - start] = 1'b1;
        else hits[(NUM_SENSORS - start) % NUM_SENSORS] = 1'b1;
      end
      3: hits = ($urandom_range(0, 3) == 0) ? '1 : NUM_SENSORS'($urandom);
      4: hits[$urandom_range(0, NUM_SENSORS - 1)] = 1'b1;
      default: ;
    endcase
    for (int i = 0; i < NUM_SENSORS; i++)
      push_sample(KIND_MEASURE, i,
                  hits[i] ? $urandom_range(0, 250) : $urandom_range(1008, 1023),
                  i == NUM_SENSORS - 1);
  endtask

  task automatic queue_ragged();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++)
      push_sample(KIND_MEASURE,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 17),
                  $urandom_range(0, 1023),
                  (i == n - 1) || ($urandom_range(0, 7) == 0));
  endtask

  // enough hits on one sensor to wrap the running sums for most sensors
  task automatic queue_overflow();
    int s, n;
    s = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 17) : 9;
    n = $urandom_range(33, 40);
    for (int i = 0; i < n; i++) push_sample(KIND_MEASURE, s, $urandom_range(0, 100), i == n - 1);
  endtask

  task automatic queue_calibration();
    repeat ($urandom_range(1, 3))
      push_sample(KIND_CALIBRATE, $urandom_range(0, 19), $urandom_range(900, 1023),
                  1'($urandom_range(0, 1)));
  endtask

  task automatic queue_random(int n);
    int first, pick;
    first = stim_count;
    while (stim_count - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) queue_scan();
      else if (pick < 80) queue_ragged();
      else if (pick < 85) queue_overflow();
      else if (pick < 93) queue_calibration();
      else push_sample(KIND_MEASURE, $urandom_range(0, 31), $urandom_range(0, 1023),
                       1'($urandom_range(0, 1)));
    end
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_margin(logic [MARGIN_BITS-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    margins_used++;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_directed();
    for (int i = 0; i < NUM_SENSORS; i++)
      push_sample(KIND_CALIBRATE, i, $urandom_range(900, 1000), 1'b0);
    queue_random(280);
    settle();

    write_margin('0);
    queue_random(240);
    settle();

    // margin at full scale: nothing can be detected
    write_margin('1);
    queue_random(100);
    settle();

    write_margin(MARGIN_BITS'($urandom_range(1, 1022)));
    queue_random(240);
    settle();

    write_margin(MARGIN_RESET);
    push_sample(KIND_CALIBRATE, 7, 0, 1'b0);
    queue_random(130);
    settle();

    $display("%0d sample transactions, %0d frames checked over %0d margin settings",
             samples_taken, frames_checked, margins_used + 1);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("** line_ring_direction_depth_unit: PASSED **");
    end else begin
      $display("** line_ring_direction_depth_unit: FAILED **");
    end
    $finish;
  end

endmodule
